[rtl/qbw_pkg.sv]
package qbw_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned ParamW      = 19;
  localparam int unsigned HeadingW    = 16;
  localparam int unsigned AngleW      = 26;
  localparam int unsigned CordicW     = 36;
  localparam int unsigned CordicTabLen = 24;
  localparam int unsigned CordicItersDefault = 16;
  localparam logic signed [ParamW-1:0] TOne = 19'sd65536;
  localparam logic signed [CoordW-1:0] StepDeltaReset = 16'sd1311;
  localparam logic signed [HeadingW-1:0] HeadingMax = 16'sd23040;
  localparam logic signed [AngleW-1:0] Angle180 = 26'sd11796480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_OUT
  } qbw_state_e;

  typedef struct packed {
    logic load;
    logic cordic_step;
    logic mul_step;
    logic finish;
  } qbw_cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic mul_last;
  } qbw_sts_t;

  function automatic logic signed [AngleW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [AngleW-1:0] r;
    case (idx)
      5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;  5'd2: r = 26'sd919879;
      5'd3: r = 26'sd466945;   5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;    5'd8: r = 26'sd14668;
      5'd9: r = 26'sd7334;     5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;     5'd13: r = 26'sd458;     5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;     5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;      5'd19: r = 26'sd7;       5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;       5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/qbw_if.sv]
interface qbw_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] random_x;
  logic signed [15:0] random_y;
  modport source (output valid, target_x, target_y, random_x, random_y, input ready);
  modport sink (input valid, target_x, target_y, random_x, random_y, output ready);
endinterface

interface qbw_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic signed [15:0] heading;
  logic reloaded;
  modport source (output valid, new_x, new_y, heading, reloaded, input ready);
  modport sink (input valid, new_x, new_y, heading, reloaded, output ready);
endinterface

interface qbw_cfg_if;
  logic valid;
  logic ready;
  logic signed [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/quadratic_bezier_walker.sv]
// Quadratic Bezier walker.
// One input beat (target point, random point) advances the object one step
// along a chain of quadratic Bezier segments and yields one output beat with
// the new position, the heading toward the target, and a reload flag.
// The curve parameter is reloaded to zero when it leaves 0..1, shifting the
// control points so that the target becomes the middle point.
// An item passes a load step, the CORDIC iterations, the steps on the single
// shared multiplier (three weights, six products) and a finish step before
// its output beat. One item is processed at a time: a new input beat is
// accepted only once the previous item has finished.
// The output register holds a finished beat while the receiver stalls; the
// next item is still accepted and computed, and waits for the register.
// The step_delta register may be written at any time through the
// configuration channel and should only change while idle.
// Reset clears control points, position and t, and sets step_delta to 1311.
module quadratic_bezier_walker #(
  parameter int unsigned CORDIC_ITERATIONS = qbw_pkg::CordicItersDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  qbw_in_if.sink    in_if,
  qbw_out_if.source out_if,
  qbw_cfg_if.sink   cfg_if
);
  import qbw_pkg::*;

  qbw_cmd_t cmd;
  qbw_sts_t sts;
  logic signed [15:0] step_delta_q;

  // The configuration register is always ready to take a beat.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delta_q <= StepDeltaReset;
    end else if (cfg_if.valid) begin
      step_delta_q <= cfg_if.data;
    end
  end

  qbw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  qbw_dp #(.Iters(CORDIC_ITERATIONS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .step_delta_i(step_delta_q),
    .tx_i(in_if.target_x), .ty_i(in_if.target_y),
    .rx_i(in_if.random_x), .ry_i(in_if.random_y),
    .new_x_o(out_if.new_x), .new_y_o(out_if.new_y),
    .heading_o(out_if.heading), .reloaded_o(out_if.reloaded)
  );

endmodule

[rtl/qbw_ctrl.sv]
module qbw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qbw_pkg::qbw_cmd_t cmd_o,
  input  qbw_pkg::qbw_sts_t sts_i
);
  import qbw_pkg::*;

  qbw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The output register holds the result; a new item may start while it waits,
  // but it may only finish once the previous beat has gone.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_o.finish) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end
  assign out_valid_o = ov_q;

endmodule

[rtl/qbw_dp.sv]
module qbw_dp #(
  parameter int unsigned Iters = qbw_pkg::CordicItersDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qbw_pkg::qbw_cmd_t              cmd_i,
  output qbw_pkg::qbw_sts_t              sts_o,
  input  logic signed [15:0]             step_delta_i,
  input  logic signed [15:0]             tx_i,
  input  logic signed [15:0]             ty_i,
  input  logic signed [15:0]             rx_i,
  input  logic signed [15:0]             ry_i,
  output logic signed [15:0]             new_x_o,
  output logic signed [15:0]             new_y_o,
  output logic signed [15:0]             heading_o,
  output logic                           reloaded_o
);
  import qbw_pkg::*;

  localparam int unsigned RunIters = (Iters > CordicTabLen) ? CordicTabLen : Iters;

  logic signed [15:0] cx_q [3];
  logic signed [15:0] cy_q [3];
  logic signed [15:0] px_q, py_q;
  logic signed [ParamW-1:0] t_q;
  logic reload_q;
  logic zero_q;

  logic signed [CordicW-1:0] x_q, y_q;
  logic signed [AngleW-1:0] z_q;
  logic [4:0] it_q;

  // Multiply sequencer: 0..2 weights, 3..8 products, x and y alternate
  logic [3:0] mstep_q;
  logic signed [35:0] w_q [3];
  logic signed [53:0] accx_q, accy_q;

  logic out_of_range;
  assign out_of_range = (t_q > TOne) || (t_q < 0);

  logic signed [16:0] dx, dy;
  assign dx = 17'(px_q) - 17'(tx_i);
  assign dy = 17'(ty_i) - 17'(py_q);

  logic signed [CordicW-1:0] xs, ys;
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  assign sts_o.cordic_last = (it_q == 5'(RunIters - 1));
  assign sts_o.mul_last = (mstep_q == 4'd8);

  logic signed [17:0] u_w;
  assign u_w = 18'(TOne) - 18'(t_q);

  // Shared multiplier operands: a weight of up to 36 bits times an 18-bit
  // coordinate or curve parameter.
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [53:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    case (mstep_q)
      4'd0: begin ma = 36'(u_w); mb = u_w; end
      4'd1: begin ma = 36'(u_w); mb = 18'(t_q); end
      4'd2: begin ma = 36'(t_q); mb = 18'(t_q); end
      4'd3: begin ma = w_q[0]; mb = 18'(cx_q[0]); end
      4'd4: begin ma = w_q[0]; mb = 18'(cy_q[0]); end
      4'd5: begin ma = w_q[1]; mb = 18'(cx_q[1]); end
      4'd6: begin ma = w_q[1]; mb = 18'(cy_q[1]); end
      4'd7: begin ma = w_q[2]; mb = 18'(cx_q[2]); end
      4'd8: begin ma = w_q[2]; mb = 18'(cy_q[2]); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  function automatic logic signed [15:0] round_sat(input logic signed [53:0] a);
    logic signed [53:0] r;
    r = (a + 54'sd2147483648) >>> 32;
    if (r > 54'sd32767) return 16'sd32767;
    if (r < -54'sd32768) return -16'sd32768;
    return 16'(r);
  endfunction

  logic signed [AngleW-1:0] zr;
  assign zr = (z_q + 26'sd256) >>> 9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
      end
      px_q <= '0;
      py_q <= '0;
      t_q <= '0;
    end else begin
      if (cmd_i.load && out_of_range) begin
        cx_q[0] <= cx_q[2];
        cy_q[0] <= cy_q[2];
        cx_q[1] <= tx_i;
        cy_q[1] <= ty_i;
        cx_q[2] <= rx_i;
        cy_q[2] <= ry_i;
        t_q <= '0;
      end
      if (cmd_i.finish) begin
        px_q <= round_sat(accx_q);
        py_q <= round_sat(accy_q);
        t_q <= t_q + ParamW'(step_delta_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      reload_q <= out_of_range;
      zero_q <= (dx == 0) && (dy == 0);
      it_q <= '0;
      mstep_q <= '0;
      accx_q <= '0;
      accy_q <= '0;
      if (dy < 0) begin
        z_q <= (dx >= 0) ? Angle180 : -Angle180;
        x_q <= -(CordicW'(dy) <<< 14);
        y_q <= -(CordicW'(dx) <<< 14);
      end else begin
        z_q <= '0;
        x_q <= CordicW'(dy) <<< 14;
        y_q <= CordicW'(dx) <<< 14;
      end
    end
    if (cmd_i.cordic_step) begin
      it_q <= it_q + 5'd1;
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_deg(it_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_deg(it_q);
      end
    end
    if (cmd_i.mul_step) begin
      mstep_q <= mstep_q + 4'd1;
      case (mstep_q)
        4'd0: w_q[0] <= 36'(prod);
        4'd1: w_q[1] <= 36'(prod) <<< 1;
        4'd2: w_q[2] <= 36'(prod);
        4'd3, 4'd5, 4'd7: accx_q <= accx_q + prod;
        default: accy_q <= accy_q + prod;
      endcase
    end
    if (cmd_i.finish) begin
      new_x_o <= round_sat(accx_q);
      new_y_o <= round_sat(accy_q);
      reloaded_o <= reload_q;
      if (zero_q) heading_o <= '0;
      else if (zr > AngleW'(HeadingMax)) heading_o <= HeadingMax;
      else if (zr < -AngleW'(HeadingMax)) heading_o <= -HeadingMax;
      else heading_o <= 16'(zr);
    end
  end

endmodule

[rtl/qbw_checker.sv]
module qbw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] heading
);
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
  ap_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (heading <= 16'sd23040 && heading >= -16'sd23040))
    else $error("heading out of range");
  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  ap_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid)) else $error("result too early");
endmodule

bind quadratic_bezier_walker qbw_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .heading(out_if.heading)
);

[test/qbw_tb_if.sv]
`timescale 1ns / 100ps

// Item and result types for the walker's channels.
package qbw_tb_pkg;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] random_x;
    logic signed [15:0] random_y;
  } step_item_t;

  typedef struct packed {
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] heading;
    logic               reloaded;
  } step_result_t;

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import qbw_pkg::*;
  import qbw_tb_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int CordicRounds = 16;
  // Extra settling time that drain() waits after the last result.
  localparam int DrainCycles = CordicRounds + 40;

  // Idling phases of the run.
  typedef enum int {
    PH_NONE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #HalfPeriod clk_i = ~clk_i;

  qbw_in_if  in_if ();
  qbw_out_if out_if ();
  qbw_cfg_if cfg_if ();

  quadratic_bezier_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // Predictor state: a private copy of the walker's control points,
  // position, curve parameter and step increment.
  logic signed [15:0] ctl_x [3];
  logic signed [15:0] ctl_y [3];
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [18:0] t_param;
  logic signed [15:0] delta_reg;

  step_result_t expected_steps[$];
  int           mismatches;
  idle_phase_e  phase;
  bit           hold_receiver;

  // Arctangent table in degrees, Q.16, one entry per CORDIC rotation.
  function automatic longint atan_step(input int i);
    longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                         29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // The >>> operator on a signed longint is a floor division by 2^n.
  function automatic logic signed [15:0] heading_deg(input longint num, input longint den);
    longint x, y, z, xs, ys;
    z = 0;
    if (num == 0 && den == 0) begin
      return '0;
    end
    x = den * 16384;
    y = num * 16384;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicRounds; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    z = (z + 256) >>> 9;
    if (z > 23040) z = 23040;
    if (z < -23040) z = -23040;
    return z[15:0];
  endfunction

  // Weighted sum of the three control points, rounded half up and saturated.
  function automatic logic signed [15:0] curve_point(input longint p0, input longint p1,
                                                    input longint p2, input longint t);
    longint u, acc, r;
    u = 65536 - t;
    acc = p0 * (u * u) + p1 * (2 * u * t) + p2 * (t * t);
    r = (acc + (longint'(1) <<< 31)) >>> 32;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Advances the predictor by one step and returns the expected beat.
  function automatic step_result_t walk_step(input step_item_t it);
    step_result_t r;
    r.reloaded = 1'b0;
    if (t_param > 19'sd65536 || t_param < 0) begin
      t_param = '0;
      ctl_x[0] = ctl_x[2];
      ctl_y[0] = ctl_y[2];
      ctl_x[1] = it.target_x;
      ctl_y[1] = it.target_y;
      ctl_x[2] = it.random_x;
      ctl_y[2] = it.random_y;
      r.reloaded = 1'b1;
    end
    r.heading = heading_deg(longint'(pos_x) - longint'(it.target_x),
                            longint'(it.target_y) - longint'(pos_y));
    r.new_x = curve_point(ctl_x[0], ctl_x[1], ctl_x[2], t_param);
    r.new_y = curve_point(ctl_y[0], ctl_y[1], ctl_y[2], t_param);
    pos_x = r.new_x;
    pos_y = r.new_y;
    t_param = t_param + 19'(delta_reg);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Output side: stall according to the phase and check every beat.
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected beat", out_if.new_x, 0);
      end else begin
        want = expected_steps.pop_front();
        if (out_if.new_x !== want.new_x) report_mismatch("new_x", out_if.new_x, want.new_x);
        if (out_if.new_y !== want.new_y) report_mismatch("new_y", out_if.new_y, want.new_y);
        if (out_if.heading !== want.heading) begin
          report_mismatch("heading", out_if.heading, want.heading);
        end
        if (out_if.reloaded !== want.reloaded) begin
          report_mismatch("reloaded", out_if.reloaded, want.reloaded);
        end
      end
    end
    if (hold_receiver) begin
      out_if.ready <= 1'b0;
    end else if (phase == PH_RECV_STALL) begin
      out_if.ready <= ($urandom_range(99) >= 82);
    end else if (phase == PH_BOTH) begin
      out_if.ready <= ($urandom_range(99) >= 6);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Offers one step beat; the expectation is queued when it is accepted.
  // Valid stays high after acceptance, so a caller that pauses drops it first.
  task automatic send_step(input step_item_t it);
    int gap;
    gap = 0;
    if (phase == PH_SEND_IDLE) begin
      while ($urandom_range(99) < 82 && gap < 40) gap++;
    end else if (phase == PH_BOTH) begin
      while ($urandom_range(99) < 6) gap++;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.target_x <= it.target_x;
    in_if.target_y <= it.target_y;
    in_if.random_x <= it.random_x;
    in_if.random_y <= it.random_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_steps.push_back(walk_step(it));
  endtask

  // Waits until every result is back, then lets the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_delta(input logic signed [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    delta_reg = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic step_item_t make_item(input int tx, input int ty, input int rx,
                                           input int ry);
    step_item_t it;
    it.target_x = tx[15:0];
    it.target_y = ty[15:0];
    it.random_x = rx[15:0];
    it.random_y = ry[15:0];
    return it;
  endfunction

  // Random content: mostly small coordinates so curves stay in range,
  // sometimes full-range values to exercise saturation.
  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(8191)) - 4096);
  endfunction

  function automatic step_item_t rand_item();
    step_item_t it;
    it.target_x = rand_coord();
    it.target_y = rand_coord();
    it.random_x = rand_coord();
    it.random_y = rand_coord();
    return it;
  endfunction

  // Directed rows. The first step after reset has t at zero and all state
  // zero, so the result is position zero with no reload.
  step_item_t directed_rows [20];

  initial begin
    step_item_t   it;
    step_result_t first;
    logic signed [15:0] deltas [6] = '{16'sd1311, 16'sd32767, -16'sd32768, 16'sd1,
                                       16'sd4096, -16'sd9000};
    int n_hold;

    phase = PH_NONE;
    hold_receiver = 1'b0;
    mismatches = 0;
    in_if.valid = 1'b0;
    in_if.target_x = '0;
    in_if.target_y = '0;
    in_if.random_x = '0;
    in_if.random_y = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int i = 0; i < 3; i++) begin
      ctl_x[i] = '0;
      ctl_y[i] = '0;
    end
    pos_x = '0;
    pos_y = '0;
    t_param = '0;
    delta_reg = 16'sd1311;

    // Extremes of every field, both zero differences, dx zero with dy
    // negative (heading of +180), and a large delta so that t passes 1.0.
    directed_rows[0]  = make_item(0, 0, 0, 0);
    directed_rows[1]  = make_item(0, -16, 100, 100);
    directed_rows[2]  = make_item(32767, 32767, -32768, -32768);
    directed_rows[3]  = make_item(-32768, -32768, 32767, 32767);
    directed_rows[4]  = make_item(-32768, 32767, 32767, -32768);
    directed_rows[5]  = make_item(32767, -32768, -32768, 32767);
    directed_rows[6]  = make_item(16, 0, 0, 16);
    directed_rows[7]  = make_item(-16, 0, 16, 0);
    directed_rows[8]  = make_item(0, 16, -16, -16);
    directed_rows[9]  = make_item(-1, -1, -1, -1);
    directed_rows[10] = make_item(1, 1, 1, 1);
    directed_rows[11] = make_item(21845, -21846, 10922, -10923);
    for (int i = 12; i < 20; i++) directed_rows[i] = make_item(i * 300, -i * 200, i, -i);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First row after reset with its result known directly.
    send_step(directed_rows[0]);
    first = expected_steps[0];
    if (first.new_x !== 16'sd0 || first.new_y !== 16'sd0 || first.heading !== 16'sd0 ||
        first.reloaded !== 1'b0) begin
      report_mismatch("first step after reset", first.heading, 0);
    end
    drain();
    // A quarter step: t passes 1.0 and the control points reload.
    write_delta(16'sd16384);
    for (int i = 1; i < 20; i++) send_step(directed_rows[i]);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_delta(deltas[p]);
      phase = idle_phase_e'(p % 4);
      for (int i = 0; i < 200; i++) begin
        // Long receiver hold-off while items keep coming.
        if (p == 2 && i == 50) begin
          fork
            begin
              hold_receiver = 1'b1;
              n_hold = 0;
              while (n_hold < 300) begin
                @(posedge clk_i);
                n_hold++;
              end
              hold_receiver = 1'b0;
            end
          join_none
        end
        // Once in this pass, the sender waits for every result before going on.
        if (p == 3 && i == 100) begin
          if (expected_steps.size() != 0) begin
            in_if.valid <= 1'b0;
            while (expected_steps.size() != 0) @(posedge clk_i);
          end
        end
        it = rand_item();
        send_step(it);
      end
      drain();
    end

    phase = PH_NONE;
    drain();
    if (mismatches == 0) begin
      $display("quadratic_bezier_walker regression: pass");
    end else begin
      $display("quadratic_bezier_walker regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("quadratic_bezier_walker regression: fail");
    $finish;
  end

endmodule
